[rtl/dcs_pkg.sv]
// Shared types, codes and constants of the doorbell change scanner.
`timescale 1ns / 1ps

package dcs_pkg;

  // Default number of I/O queue pairs
  localparam int unsigned DefaultNumIoQueues = 16;

  // Configuration port address width (five registers at byte offsets 0..16)
  localparam int unsigned CfgAddrW = 5;

  // Register reset values
  localparam logic [23:0] BaseIntervalRst = 24'd1000;
  localparam logic [31:0] MinLimitRst     = 32'd10;
  localparam logic [31:0] MaxLimitRst     = 32'd1000000;
  localparam logic        RouteRst        = 1'b1;
  localparam logic [4:0]  IoCountRst      = 5'd0;

  // Divide by ten as multiply by reciprocal, then shift
  localparam logic [31:0] Recip10      = 32'hCCCC_CCCD;
  localparam int unsigned Recip10Shift = 35;

  // Upper interval bound factor over the base interval
  localparam logic [31:0] HiFactor = 32'd100;

  // Input word modes
  typedef enum logic [1:0] {
    MODE_CTRL_WRITE = 2'd0,
    MODE_DOORBELL   = 2'd1,
    MODE_QUEUE_MARK = 2'd2,
    MODE_POLL       = 2'd3
  } mode_e;

  // Result word kinds
  typedef enum logic [2:0] {
    EVT_ENABLED      = 3'd0,
    EVT_DISABLED     = 3'd1,
    EVT_CTRL_CHANGED = 3'd2,
    EVT_ADMIN_TAIL   = 3'd3,
    EVT_IO_TAIL      = 3'd4,
    EVT_SUMMARY      = 3'd5
  } event_kind_e;

  // Configuration register indexes (paddr[4:2])
  typedef enum logic [2:0] {
    REG_BASE  = 3'd0,
    REG_MIN   = 3'd1,
    REG_MAX   = 3'd2,
    REG_ROUTE = 3'd3,
    REG_COUNT = 3'd4
  } cfg_reg_e;

  // Shared arithmetic unit operations
  typedef enum logic [1:0] {
    ALU_MUL = 2'd0,
    ALU_ADD = 2'd1,
    ALU_MAX = 2'd2,
    ALU_MIN = 2'd3
  } alu_op_e;

  // Sequencer states
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CTRL,
    ST_SCAN,
    ST_LO,
    ST_LO_CLAMP,
    ST_HI,
    ST_HI_CLAMP,
    ST_STEP,
    ST_CLAMP
  } state_e;

  // Request to the shared arithmetic unit
  typedef struct packed {
    alu_op_e     op;
    logic [32:0] a;
    logic [32:0] b;
  } alu_req_t;

endpackage

[rtl/doorbell_change_scanner.sv]
// Top level: config registers, control tracking and the poll sequencer.
`timescale 1ns / 1ps

// Doorbell change scanner. Control-word writes, doorbell writes and queue
// create/delete marks leave busy low and give no result. A poll tick keeps
// busy high through the control check and, when scanning is on (control bit
// 0 and the ready flag set), a scan of one queue per cycle (admin first)
// through the single read port of the tail store up to count, which is
// io_queue_count limited to NUM_IO_QUEUES, then through six steps of the
// shared multiply/compare unit for the interval update. Each result word is
// shown for exactly one cycle with result_valid_o and cannot be held off;
// the summary word (last_o high) appears in the cycle in which busy falls,
// and a new item may be started in that same cycle. Stored tails read as
// zero after reset through valid bits, with no clearing pass.

module doorbell_change_scanner
  import dcs_pkg::*;
#(
  parameter int unsigned NUM_IO_QUEUES = DefaultNumIoQueues
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  // Configuration port
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [CfgAddrW-1:0] paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready,
  // Command side
  input  logic                start,
  output logic                busy,
  input  logic [1:0]          mode_i,
  input  logic [5:0]          reg_index_i,
  input  logic [31:0]         write_value_i,
  input  logic [4:0]          queue_id_i,
  input  logic                created_i,
  // Result side
  output logic                result_valid_o,
  output logic [2:0]          event_kind_o,
  output logic [4:0]          queue_number_o,
  output logic [15:0]         new_tail_o,
  output logic                route_o,
  output logic                had_work_o,
  output logic [31:0]         next_interval_us_o,
  output logic                last_o
);

  localparam int unsigned Depth = NUM_IO_QUEUES + 1;
  localparam int unsigned AddrW = $clog2(Depth);
  localparam logic [AddrW-1:0] MaxCount = AddrW'(NUM_IO_QUEUES);
  localparam logic [Depth-1:0] LiveRst  = Depth'(1);

  // Configuration registers
  logic [23:0] base_q;
  logic [31:0] min_q;
  logic [31:0] max_q;
  logic        route_cfg_q;
  logic [4:0]  io_count_q;
  logic        cfg_we;

  // Sequencer and tracking state
  state_e           state_q, state_d;
  logic [AddrW-1:0] q_q, q_d;
  logic             work_q, work_d;
  logic             ready_q, ready_d;
  logic [31:0]      shadow_q, shadow_d;
  logic [31:0]      ctrl_seen_q, ctrl_seen_d;
  logic [Depth-1:0] live_q, live_d;
  logic [31:0]      poll_q, poll_d;
  logic [31:0]      lo_q, lo_d;
  logic [31:0]      hi_q, hi_d;
  logic [32:0]      iv_q, iv_d;

  // Result register
  logic        res_valid_q, res_valid_d;
  event_kind_e res_kind_q, res_kind_d;
  logic [4:0]  res_queue_q, res_queue_d;
  logic [15:0] res_tail_q, res_tail_d;
  logic        res_route_q, res_route_d;
  logic        res_work_q, res_work_d;
  logic [31:0] res_next_q, res_next_d;
  logic        res_last_q, res_last_d;

  // Store and unit hookup
  logic             accept;
  logic             db_in_range;
  logic             qid_in_range;
  logic             db_we;
  logic             seen_we;
  logic [AddrW-1:0] rd_addr;
  logic [15:0]      tail_rd;
  logic [15:0]      seen_rd;
  logic [AddrW-1:0] count_eff;
  alu_req_t         alu_req;
  logic [63:0]      alu_y;

  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite;
  assign busy   = (state_q != ST_IDLE);
  assign accept = start && !busy;

  // Write configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base_q      <= BaseIntervalRst;
      min_q       <= MinLimitRst;
      max_q       <= MaxLimitRst;
      route_cfg_q <= RouteRst;
      io_count_q  <= IoCountRst;
    end else if (cfg_we) begin
      unique case (cfg_reg_e'(paddr[4:2]))
        REG_BASE:  base_q      <= pwdata[23:0];
        REG_MIN:   min_q       <= pwdata;
        REG_MAX:   max_q       <= pwdata;
        REG_ROUTE: route_cfg_q <= pwdata[0];
        REG_COUNT: io_count_q  <= pwdata[4:0];
        default: ;
      endcase
    end
  end

  // Read back configuration registers
  always_comb begin
    unique case (cfg_reg_e'(paddr[4:2]))
      REG_BASE:  prdata = {8'd0, base_q};
      REG_MIN:   prdata = min_q;
      REG_MAX:   prdata = max_q;
      REG_ROUTE: prdata = {31'd0, route_cfg_q};
      REG_COUNT: prdata = {27'd0, io_count_q};
      default:   prdata = '0;
    endcase
  end

  // Range checks on incoming words and the scan limit
  assign db_in_range  = !reg_index_i[0] && (32'(reg_index_i[5:1]) <= NUM_IO_QUEUES);
  assign qid_in_range = (queue_id_i != 5'd0) && (32'(queue_id_i) <= NUM_IO_QUEUES);
  assign count_eff    = (32'(io_count_q) > NUM_IO_QUEUES) ? MaxCount : AddrW'(io_count_q);

  dcs_tail_store #(
    .NumIoQueues (NUM_IO_QUEUES)
  ) u_store (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .db_we_i      (db_we),
    .db_waddr_i   (AddrW'(reg_index_i[5:1])),
    .db_wdata_i   (write_value_i[15:0]),
    .seen_we_i    (seen_we),
    .seen_waddr_i (q_q),
    .seen_wdata_i (tail_rd),
    .rd_addr_i    (rd_addr),
    .tail_o       (tail_rd),
    .seen_o       (seen_rd)
  );

  dcs_alu u_alu (
    .req_i (alu_req),
    .y_o   (alu_y)
  );

  // State and tracking registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      q_q         <= '0;
      work_q      <= 1'b0;
      ready_q     <= 1'b0;
      shadow_q    <= '0;
      ctrl_seen_q <= '0;
      live_q      <= LiveRst;
      poll_q      <= 32'(BaseIntervalRst);
      res_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      q_q         <= q_d;
      work_q      <= work_d;
      ready_q     <= ready_d;
      shadow_q    <= shadow_d;
      ctrl_seen_q <= ctrl_seen_d;
      live_q      <= live_d;
      poll_q      <= poll_d;
      res_valid_q <= res_valid_d;
    end
  end

  // Interval temporaries and result payload
  always_ff @(posedge clk_i) begin
    lo_q <= lo_d;
    hi_q <= hi_d;
    iv_q <= iv_d;
    if (res_valid_d) begin
      res_kind_q  <= res_kind_d;
      res_queue_q <= res_queue_d;
      res_tail_q  <= res_tail_d;
      res_route_q <= res_route_d;
      res_work_q  <= res_work_d;
      res_next_q  <= res_next_d;
      res_last_q  <= res_last_d;
    end
  end

  // Sequence one item
  always_comb begin
    state_d     = state_q;
    q_d         = q_q;
    work_d      = work_q;
    ready_d     = ready_q;
    shadow_d    = shadow_q;
    ctrl_seen_d = ctrl_seen_q;
    live_d      = live_q;
    poll_d      = poll_q;
    lo_d        = lo_q;
    hi_d        = hi_q;
    iv_d        = iv_q;
    res_valid_d = 1'b0;
    res_kind_d  = EVT_SUMMARY;
    res_queue_d = '0;
    res_tail_d  = '0;
    res_route_d = 1'b0;
    res_work_d  = 1'b0;
    res_next_d  = '0;
    res_last_d  = 1'b0;
    db_we       = 1'b0;
    seen_we     = 1'b0;
    rd_addr     = '0;
    alu_req     = '{op: ALU_ADD, a: '0, b: '0};

    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          unique case (mode_e'(mode_i))
            MODE_CTRL_WRITE: shadow_d = write_value_i;
            MODE_DOORBELL:   db_we = db_in_range;
            MODE_QUEUE_MARK: begin
              if (qid_in_range) live_d[AddrW'(queue_id_i)] = created_i;
            end
            MODE_POLL: begin
              work_d  = 1'b0;
              state_d = ST_CTRL;
            end
            default: ;
          endcase
        end
      end

      // Report a control word change, track the enable edge
      ST_CTRL: begin
        if (shadow_q != ctrl_seen_q) begin
          work_d      = 1'b1;
          ctrl_seen_d = shadow_q;
          res_valid_d = 1'b1;
          res_kind_d  = EVT_CTRL_CHANGED;
          if (shadow_q[0] && !ctrl_seen_q[0]) begin
            ready_d    = 1'b1;
            res_kind_d = EVT_ENABLED;
          end else if (!shadow_q[0] && ctrl_seen_q[0]) begin
            ready_d    = 1'b0;
            res_kind_d = EVT_DISABLED;
          end
        end
        if (shadow_q[0] && ready_d) begin
          q_d     = '0;
          state_d = ST_SCAN;
        end else begin
          state_d = ST_LO;
        end
      end

      // Compare one queue per cycle while the next one is read
      ST_SCAN: begin
        rd_addr = (q_q == count_eff) ? '0 : AddrW'(q_q + 1'b1);
        if (live_q[q_q] && (tail_rd != seen_rd)) begin
          seen_we     = 1'b1;
          work_d      = 1'b1;
          res_valid_d = 1'b1;
          res_kind_d  = (q_q == '0) ? EVT_ADMIN_TAIL : EVT_IO_TAIL;
          res_queue_d = 5'(q_q);
          res_tail_d  = tail_rd;
          res_route_d = route_cfg_q;
        end
        if (q_q == count_eff) begin
          state_d = ST_LO;
        end else begin
          q_d = AddrW'(q_q + 1'b1);
        end
      end

      // Lower bound: base / 10
      ST_LO: begin
        alu_req = '{op: ALU_MUL, a: 33'(base_q), b: 33'(Recip10)};
        lo_d    = 32'(alu_y >> Recip10Shift);
        state_d = ST_LO_CLAMP;
      end

      // Raise lower bound to the global minimum
      ST_LO_CLAMP: begin
        alu_req = '{op: ALU_MAX, a: 33'(lo_q), b: 33'(min_q)};
        lo_d    = alu_y[31:0];
        state_d = ST_HI;
      end

      // Upper bound: base * 100
      ST_HI: begin
        alu_req = '{op: ALU_MUL, a: 33'(base_q), b: 33'(HiFactor)};
        hi_d    = alu_y[31:0];
        state_d = ST_HI_CLAMP;
      end

      // Lower upper bound to the global maximum
      ST_HI_CLAMP: begin
        alu_req = '{op: ALU_MIN, a: 33'(hi_q), b: 33'(max_q)};
        hi_d    = alu_y[31:0];
        state_d = ST_STEP;
      end

      // Halve on work, else grow by a quarter without wrap
      ST_STEP: begin
        if (work_q) begin
          alu_req = '{op: ALU_ADD, a: 33'(poll_q[31:1]), b: '0};
        end else begin
          alu_req = '{op: ALU_ADD, a: 33'(poll_q), b: 33'(poll_q[31:2])};
        end
        iv_d    = alu_y[32:0];
        state_d = ST_CLAMP;
      end

      // Clamp, store the new interval and send the summary
      ST_CLAMP: begin
        if (work_q) begin
          alu_req = '{op: ALU_MAX, a: iv_q, b: 33'(lo_q)};
        end else begin
          alu_req = '{op: ALU_MIN, a: iv_q, b: 33'(hi_q)};
        end
        poll_d      = alu_y[31:0];
        res_valid_d = 1'b1;
        res_kind_d  = EVT_SUMMARY;
        res_work_d  = work_q;
        res_next_d  = alu_y[31:0];
        res_last_d  = 1'b1;
        state_d     = ST_IDLE;
      end

      default: state_d = ST_IDLE;
    endcase
  end

  assign result_valid_o     = res_valid_q;
  assign event_kind_o       = res_kind_q;
  assign queue_number_o     = res_queue_q;
  assign new_tail_o         = res_tail_q;
  assign route_o            = res_route_q;
  assign had_work_o         = res_work_q;
  assign next_interval_us_o = res_next_q;
  assign last_o             = res_last_q;

endmodule

[rtl/dcs_alu.sv]
// Shared multiply, add and min/max unit used by the interval update steps.
`timescale 1ns / 1ps

module dcs_alu
  import dcs_pkg::*;
(
  input  alu_req_t    req_i,
  output logic [63:0] y_o
);

  // Pick one operation per cycle
  always_comb begin
    unique case (req_i.op)
      ALU_MUL: y_o = 64'(req_i.a[31:0]) * 64'(req_i.b[31:0]);
      ALU_ADD: y_o = 64'(req_i.a) + 64'(req_i.b);
      ALU_MAX: y_o = (req_i.a > req_i.b) ? 64'(req_i.a) : 64'(req_i.b);
      ALU_MIN: y_o = (req_i.a < req_i.b) ? 64'(req_i.a) : 64'(req_i.b);
      default: y_o = '0;
    endcase
  end

endmodule

[rtl/dcs_tail_store.sv]
// Submission tail and seen-tail memories with per-entry valid bits.
`timescale 1ns / 1ps

module dcs_tail_store
  import dcs_pkg::*;
#(
  parameter int unsigned NumIoQueues = DefaultNumIoQueues
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 db_we_i,
  input  logic [$clog2(NumIoQueues + 1)-1:0]   db_waddr_i,
  input  logic [15:0]                          db_wdata_i,
  input  logic                                 seen_we_i,
  input  logic [$clog2(NumIoQueues + 1)-1:0]   seen_waddr_i,
  input  logic [15:0]                          seen_wdata_i,
  input  logic [$clog2(NumIoQueues + 1)-1:0]   rd_addr_i,
  output logic [15:0]                          tail_o,
  output logic [15:0]                          seen_o
);

  localparam int unsigned Depth = NumIoQueues + 1;

  logic [15:0]      tail_mem [Depth];
  logic [15:0]      seen_mem [Depth];
  logic [Depth-1:0] tail_vld_q;
  logic [Depth-1:0] seen_vld_q;
  logic [15:0]      tail_rd_q;
  logic [15:0]      seen_rd_q;
  logic             tail_rd_vld_q;
  logic             seen_rd_vld_q;

  // Track which entries were written since reset
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tail_vld_q    <= '0;
      seen_vld_q    <= '0;
      tail_rd_vld_q <= 1'b0;
      seen_rd_vld_q <= 1'b0;
    end else begin
      if (db_we_i) tail_vld_q[db_waddr_i] <= 1'b1;
      if (seen_we_i) seen_vld_q[seen_waddr_i] <= 1'b1;
      tail_rd_vld_q <= tail_vld_q[rd_addr_i];
      seen_rd_vld_q <= seen_vld_q[rd_addr_i];
    end
  end

  // Write and read the arrays, read data registered
  always_ff @(posedge clk_i) begin
    if (db_we_i) tail_mem[db_waddr_i] <= db_wdata_i;
    if (seen_we_i) seen_mem[seen_waddr_i] <= seen_wdata_i;
    tail_rd_q <= tail_mem[rd_addr_i];
    seen_rd_q <= seen_mem[rd_addr_i];
  end

  // Unwritten entries read as zero
  assign tail_o = tail_rd_vld_q ? tail_rd_q : 16'd0;
  assign seen_o = seen_rd_vld_q ? seen_rd_q : 16'd0;

endmodule

[rtl/dcs_checker.sv]
// Port-level checks of the doorbell change scanner and their bind.
`timescale 1ns / 1ps

module dcs_checker
  import dcs_pkg::*;
(
  input logic        clk_i,
  input logic        rst_ni,
  input logic        start,
  input logic        busy,
  input logic [1:0]  mode_i,
  input logic        result_valid_o,
  input logic [2:0]  event_kind_o,
  input logic        last_o
);

  // A poll tick keeps the block busy in the next cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy && (mode_i == MODE_POLL)) |=> busy)
    else $error("poll tick accepted without going busy");

  // A write word leaves the block idle and gives no result
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy && (mode_i != MODE_POLL)) |=> (!busy && !result_valid_o))
    else $error("write word made the block busy or gave a result");

  // The final word of a tick is the summary
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && last_o) |-> (event_kind_o == EVT_SUMMARY))
    else $error("last word is not a summary");

  // A summary always closes the tick
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && (event_kind_o == EVT_SUMMARY)) |-> last_o)
    else $error("summary without last");

  // Words before the summary arrive while the tick is still running
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && !last_o) |-> busy)
    else $error("event word outside a running tick");

endmodule

bind doorbell_change_scanner dcs_checker u_dcs_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .start          (start),
  .busy           (busy),
  .mode_i         (mode_i),
  .result_valid_o (result_valid_o),
  .event_kind_o   (event_kind_o),
  .last_o         (last_o)
);
